FILE: rtl/rbm_pkg.sv
// Shared types and constants for the region block mosaic.
// Holds the pixel item structs, the bounds unit status struct and the fixed
// reciprocal constants. No dependencies.
package rbm_pkg;

  // Fixed field and register widths.
  localparam int PIX_W      = 24;
  localparam int FACE_W     = 14;
  localparam int SIZE_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Frame height limit and the row counter and row bound widths.
  localparam int MAX_ROWS = 2048;
  localparam int ROW_W    = 11;
  localparam int ROW_BW   = 12;

  // Shared multiplier operand width in the bounds unit.
  localparam int MUL_W = 28;

  // floor(x / 10000) = (x * R10K) >> 40, exact for x below 2**27.
  localparam logic [MUL_W-1:0] R10K       = 28'd109951163;
  localparam int               R10K_SHIFT = 40;
  // floor(x / 10) = (x * R10) >> 19 and floor(x / 5) = (x * R10) >> 18,
  // both exact well beyond the values seen here.
  localparam logic [MUL_W-1:0] R10        = 28'd52429;
  localparam int               R10_SHIFT  = 19;
  localparam int               R5_SHIFT   = 18;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       in_region;
  } pix_out_t;

  // Status of the bounds unit as seen by the pixel path.
  typedef struct packed {
    logic busy;   // bounds or phases are being recomputed
    logic load;   // phase values are valid for one cycle
  } bnd_stat_t;

endpackage

FILE: rtl/rbm_bounds.sv
// Bounds unit of the region block mosaic: scales the face rectangle to
// pixels, grows and clamps it, and re-derives the block phases.
// Uses rbm_pkg; one shared registered multiplier, sixteen steps per axis.
module rbm_bounds #(
  parameter int STEP     = 10,
  parameter int MAX_COLS = 2048,
  localparam int CSW = $clog2(MAX_COLS + 1),
  localparam int CW  = $clog2(MAX_COLS),
  localparam int CBW = CW + 1,
  localparam int PW  = $clog2(STEP)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rbm_pkg::FACE_W-1:0]    face_left,
  input  logic [rbm_pkg::FACE_W-1:0]    face_top,
  input  logic [rbm_pkg::FACE_W-1:0]    face_width,
  input  logic [rbm_pkg::FACE_W-1:0]    face_height,
  input  logic [CSW-1:0]                cols,
  input  logic [rbm_pkg::SIZE_W-1:0]    rows,
  input  logic [CW-1:0]                 col_pos,
  input  logic [rbm_pkg::ROW_W-1:0]     row_pos,
  output rbm_pkg::bnd_stat_t            stat,
  output logic [CBW-1:0]                x_lo,
  output logic [CBW-1:0]                x_hi,
  output logic [rbm_pkg::ROW_BW-1:0]    y_lo,
  output logic [rbm_pkg::ROW_BW-1:0]    y_hi,
  output logic [PW-1:0]                 col_phase_ld,
  output logic [CW-1:0]                 block_col_ld,
  output logic [PW-1:0]                 row_phase_ld
);

  localparam int AW  = (CSW > rbm_pkg::SIZE_W) ? CSW : rbm_pkg::SIZE_W;
  localparam int VW  = AW + 1;
  localparam int SW  = AW + 4;
  localparam int KS  = AW + 8;
  localparam int RS  = (2 ** KS + STEP - 1) / STEP;
  localparam int MOW = rbm_pkg::MUL_W;
  localparam int MW  = 2 * MOW;

  // Sequencer steps, one per cycle, run once for columns and once for rows.
  localparam logic [3:0] ST_ORG      = 4'd0;
  localparam logic [3:0] ST_P_MUL    = 4'd1;
  localparam logic [3:0] ST_LEN      = 4'd2;
  localparam logic [3:0] ST_W_MUL    = 4'd3;
  localparam logic [3:0] ST_W        = 4'd4;
  localparam logic [3:0] ST_C10_MUL  = 4'd5;
  localparam logic [3:0] ST_EXT_MUL  = 4'd6;
  localparam logic [3:0] ST_CLAMP    = 4'd7;
  localparam logic [3:0] ST_LIMIT    = 4'd8;
  localparam logic [3:0] ST_NB_MUL   = 4'd9;
  localparam logic [3:0] ST_NB       = 4'd10;
  localparam logic [3:0] ST_SPAN_MUL = 4'd11;
  localparam logic [3:0] ST_HI       = 4'd12;
  localparam logic [3:0] ST_BLK      = 4'd13;
  localparam logic [3:0] ST_BLK_MUL  = 4'd14;
  localparam logic [3:0] ST_PHASE    = 4'd15;

  logic [3:0]                  step;
  logic                        axis;
  logic                        busy;
  logic                        load;
  logic [MW-1:0]               mul;
  logic [MOW-1:0]              op_a;
  logic [MOW-1:0]              op_b;
  logic [rbm_pkg::FACE_W-1:0]  org;
  logic [rbm_pkg::FACE_W-1:0]  len;
  logic [AW-1:0]               size;
  logic [AW-1:0]               pos;
  logic [VW-1:0]               p;
  logic [VW-1:0]               w;
  logic [VW-1:0]               c10;
  logic [VW-1:0]               s;
  logic [VW-1:0]               nb;
  logic [VW-1:0]               dc;
  logic [VW-1:0]               hi_v;
  logic [CW-1:0]               blk;
  logic [PW-1:0]               ph;
  logic signed [SW-1:0]        ext;
  logic signed [SW-1:0]        s_sx;
  logic signed [SW-1:0]        size_sx;
  logic signed [SW-1:0]        step_sx;
  logic signed [SW-1:0]        ext_adj;
  logic signed [SW-1:0]        ext_round;
  logic                        ext_over;
  logic                        ext_pos;

  assign org  = axis ? face_top : face_left;
  assign len  = axis ? face_height : face_width;
  assign size = axis ? AW'(rows) : AW'(cols);
  assign pos  = axis ? AW'(row_pos) : AW'(col_pos);

  assign s_sx      = $signed(SW'(s));
  assign size_sx   = $signed(SW'(size));
  assign step_sx   = $signed(SW'(STEP));
  assign ext_adj   = size_sx - s_sx - step_sx;
  assign ext_over  = (s_sx + ext + step_sx) > size_sx;
  assign ext_round = ext + $signed(SW'(STEP - 1));
  assign ext_pos   = !ext[SW-1] && (ext != '0);
  assign ph        = PW'(dc - VW'(mul));

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      ST_ORG: begin
        op_a = MOW'(org);
        op_b = MOW'(size);
      end
      ST_P_MUL, ST_W_MUL: begin
        op_a = mul[MOW-1:0];
        op_b = rbm_pkg::R10K;
      end
      ST_LEN: begin
        op_a = MOW'(len);
        op_b = MOW'(size);
      end
      ST_C10_MUL: begin
        op_a = MOW'(w) + MOW'(9);
        op_b = rbm_pkg::R10;
      end
      ST_EXT_MUL: begin
        op_a = (MOW'(w) << 2) + (MOW'(w) << 1);
        op_b = rbm_pkg::R10;
      end
      ST_NB_MUL: begin
        op_a = MOW'($unsigned(ext_round));
        op_b = MOW'(RS);
      end
      ST_SPAN_MUL: begin
        op_a = MOW'(nb);
        op_b = MOW'(STEP);
      end
      ST_HI: begin
        op_a = MOW'(dc);
        op_b = MOW'(RS);
      end
      ST_BLK_MUL: begin
        op_a = MOW'(blk);
        op_b = MOW'(STEP);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Datapath registers: mul every cycle, the others only in their own steps.
  always_ff @(posedge clk) begin
    mul <= op_a * op_b;
    case (step)
      ST_LEN:      p <= VW'(mul >> rbm_pkg::R10K_SHIFT);
      ST_W:        w <= VW'(mul >> rbm_pkg::R10K_SHIFT);
      ST_EXT_MUL:  c10 <= VW'(mul >> rbm_pkg::R10_SHIFT);
      ST_CLAMP: begin
        ext <= $signed(SW'(mul >> rbm_pkg::R5_SHIFT));
        s   <= (p < c10) ? '0 : p - c10;
      end
      ST_LIMIT: begin
        if (ext_over) begin
          ext <= ext_adj;
        end
      end
      ST_NB:       nb <= VW'(mul >> KS);
      ST_SPAN_MUL: dc <= VW'(pos) - s;
      ST_HI:       hi_v <= ext_pos ? s + VW'(mul) : s;
      ST_BLK:      blk <= CW'(mul >> KS);
      default: begin
      end
    endcase
  end

  // Sequencer and result registers. The reset values are the bounds of the
  // reset configuration, which are all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      load         <= 1'b0;
      step         <= ST_ORG;
      axis         <= 1'b0;
      x_lo         <= '0;
      x_hi         <= '0;
      y_lo         <= '0;
      y_hi         <= '0;
      col_phase_ld <= '0;
      block_col_ld <= '0;
      row_phase_ld <= '0;
    end else begin
      load <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= ST_ORG;
        axis <= 1'b0;
      end else if (load) begin
        busy <= 1'b0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == ST_PHASE) begin
          if (!axis) begin
            x_lo         <= CBW'(s);
            x_hi         <= CBW'(hi_v);
            col_phase_ld <= ph;
            block_col_ld <= blk;
            axis         <= 1'b1;
          end else begin
            y_lo         <= rbm_pkg::ROW_BW'(s);
            y_hi         <= rbm_pkg::ROW_BW'(hi_v);
            row_phase_ld <= ph;
            load         <= 1'b1;
          end
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.load = load;

  a_load_ends_busy : assert property (@(posedge clk) disable iff (rst)
    load && !start |=> !busy)
    else $error("bounds unit still busy after the phase load");

  a_start_sets_busy : assert property (@(posedge clk) disable iff (rst)
    start |=> busy && step == ST_ORG && !axis)
    else $error("bounds unit did not restart on a register write");

  a_load_only_when_busy : assert property (@(posedge clk) disable iff (rst)
    load |-> busy && axis)
    else $error("phase load outside a row pass");

endmodule

FILE: rtl/region_block_mosaic.sv
// Region block mosaic top level: pixel path, anchor line store, position
// and phase counters, configuration registers and output queue.
// Uses rbm_pkg and rbm_bounds.
//
//   channel   direction  handshake                    payload
//   in        sink       in_valid / in_ready          in_data  (rbm_pkg::pix_in_t)
//   out       source     out_valid / out_ready        out_data (rbm_pkg::pix_out_t)
//   cfg       sink       cfg_write, no back-pressure  cfg_index, cfg_data
//
// One item is taken every cycle while in_ready is high; its result passes
// through one pipeline register, with the anchor store read, then a
// two-entry output queue on its way to out_valid.
// Every register write starts a recompute of the bounds and block phases in
// the shared-multiplier bounds unit: in_ready stays low after the write until
// the recompute is done. Reset needs no recompute, its bounds are all zero.
// A stalled output fills the queue and then the pipeline register; the stall
// lowers in_ready only when both are full, so no item is lost or repeated.
module region_block_mosaic #(
  parameter int STEP         = 10,
  parameter int MAX_COLS     = 2048,
  parameter int ANCHOR_DEPTH = 205
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rbm_pkg::pix_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rbm_pkg::pix_out_t                out_data,
  input  logic                             cfg_write,
  input  logic [rbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CSW = $clog2(MAX_COLS + 1);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int CBW = CW + 1;
  localparam int PW  = $clog2(STEP);
  localparam int AIW = (ANCHOR_DEPTH > 1) ? $clog2(ANCHOR_DEPTH) : 1;
  localparam int IXW = (AIW > CW) ? AIW : CW;
  localparam int RW  = rbm_pkg::ROW_W;
  localparam int RBW = rbm_pkg::ROW_BW;

  // Register indexes of the configuration port.
  localparam logic [rbm_pkg::CFG_IDX_W-1:0] REG_FACE_LEFT   = 3'd0;
  localparam logic [rbm_pkg::CFG_IDX_W-1:0] REG_FACE_TOP    = 3'd1;
  localparam logic [rbm_pkg::CFG_IDX_W-1:0] REG_FACE_WIDTH  = 3'd2;
  localparam logic [rbm_pkg::CFG_IDX_W-1:0] REG_FACE_HEIGHT = 3'd3;
  localparam logic [rbm_pkg::CFG_IDX_W-1:0] REG_FRAME_COLS  = 3'd4;
  localparam logic [rbm_pkg::CFG_IDX_W-1:0] REG_FRAME_ROWS  = 3'd5;

  // Configuration registers.
  logic [rbm_pkg::FACE_W-1:0] face_left;
  logic [rbm_pkg::FACE_W-1:0] face_top;
  logic [rbm_pkg::FACE_W-1:0] face_width;
  logic [rbm_pkg::FACE_W-1:0] face_height;
  logic [rbm_pkg::SIZE_W-1:0] frame_cols;
  logic [rbm_pkg::SIZE_W-1:0] frame_rows;
  logic                       cfg_start;

  // Frame size after saturation.
  logic [CSW-1:0]             cw;
  logic [rbm_pkg::SIZE_W-1:0] ch;

  // Bounds unit results.
  rbm_pkg::bnd_stat_t stat;
  logic [CBW-1:0]     x_lo;
  logic [CBW-1:0]     x_hi;
  logic [RBW-1:0]     y_lo;
  logic [RBW-1:0]     y_hi;
  logic [PW-1:0]      col_phase_ld;
  logic [CW-1:0]      block_col_ld;
  logic [PW-1:0]      row_phase_ld;

  // Position and block phase of the next pixel.
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [PW-1:0] col_phase;
  logic [PW-1:0] row_phase;
  logic [CW-1:0] block_col;

  // Pixel path, first stage.
  logic                       accept;
  logic [rbm_pkg::PIX_W-1:0]  pix;
  logic [CW-1:0]              c;
  logic [RW-1:0]              y;
  logic [PW-1:0]              cph;
  logic [PW-1:0]              rph;
  logic [CW-1:0]              blk;
  logic                       in_rect;
  logic                       hit;
  logic                       is_anchor;
  logic [IXW-1:0]             blk_wide;
  logic [AIW-1:0]             aidx;
  logic                       col_last;
  logic [CW-1:0]              col_count_next;
  logic [RW-1:0]              row_count_next;
  logic [PW-1:0]              col_phase_next;
  logic [PW-1:0]              row_phase_next;
  logic [CW-1:0]              block_col_next;

  // Anchor line store, one RGB entry per block column.
  logic [rbm_pkg::PIX_W-1:0]  anchor_store [ANCHOR_DEPTH];
  logic [rbm_pkg::PIX_W-1:0]  anchor_rd;

  // Pipeline register between the store read and the output queue.
  logic                       p_valid;
  logic [rbm_pkg::PIX_W-1:0]  p_pix;
  logic                       p_hit;
  logic                       p_anchor;
  logic                       p_move;
  logic [rbm_pkg::PIX_W-1:0]  res_pix;
  rbm_pkg::pix_out_t          res;

  // Two-entry output queue.
  rbm_pkg::pix_out_t fifo_q [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fifo_count;
  logic              pop;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  assign cfg_start = cfg_write &&
                     (cfg_index inside {[REG_FACE_LEFT:REG_FRAME_ROWS]});

  always_ff @(posedge clk) begin
    if (rst) begin
      face_left   <= '0;
      face_top    <= '0;
      face_width  <= '0;
      face_height <= '0;
      frame_cols  <= rbm_pkg::SIZE_W'(640);
      frame_rows  <= rbm_pkg::SIZE_W'(480);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FACE_LEFT:   face_left   <= cfg_data;
        REG_FACE_TOP:    face_top    <= cfg_data;
        REG_FACE_WIDTH:  face_width  <= cfg_data;
        REG_FACE_HEIGHT: face_height <= cfg_data;
        REG_FRAME_COLS:  frame_cols  <= rbm_pkg::SIZE_W'(cfg_data);
        REG_FRAME_ROWS:  frame_rows  <= rbm_pkg::SIZE_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Zero sizes count as one; oversized frames are cut to the limits.
  always_comb begin
    if (frame_cols == '0) begin
      cw = CSW'(1);
    end else if (32'(frame_cols) > MAX_COLS) begin
      cw = CSW'(MAX_COLS);
    end else begin
      cw = CSW'(frame_cols);
    end
    if (frame_rows == '0) begin
      ch = rbm_pkg::SIZE_W'(1);
    end else if (32'(frame_rows) > rbm_pkg::MAX_ROWS) begin
      ch = rbm_pkg::SIZE_W'(rbm_pkg::MAX_ROWS);
    end else begin
      ch = frame_rows;
    end
  end

  rbm_bounds #(
    .STEP     (STEP),
    .MAX_COLS (MAX_COLS)
  ) u_bounds (
    .clk          (clk),
    .rst          (rst),
    .start        (cfg_start),
    .face_left    (face_left),
    .face_top     (face_top),
    .face_width   (face_width),
    .face_height  (face_height),
    .cols         (cw),
    .rows         (ch),
    .col_pos      (col_count),
    .row_pos      (row_count),
    .stat         (stat),
    .x_lo         (x_lo),
    .x_hi         (x_hi),
    .y_lo         (y_lo),
    .y_hi         (y_hi),
    .col_phase_ld (col_phase_ld),
    .block_col_ld (block_col_ld),
    .row_phase_ld (row_phase_ld)
  );

  // ---------------------------------------------------------------------
  // Pixel path
  // ---------------------------------------------------------------------
  // The input waits while the bounds are recomputed and while both the
  // pipeline register and the output queue are full.
  assign p_move   = p_valid && (fifo_count != 2'd2);
  assign in_ready = !stat.busy && (!p_valid || (fifo_count != 2'd2));
  assign accept   = in_valid && in_ready;

  assign pix = {in_data.red_in, in_data.green_in, in_data.blue_in};

  // A frame start puts the pixel at the origin. The phases are then zero,
  // which is only consulted when the region starts at the frame edge.
  assign c   = in_data.frame_start ? '0 : col_count;
  assign y   = in_data.frame_start ? '0 : row_count;
  assign cph = in_data.frame_start ? '0 : col_phase;
  assign rph = in_data.frame_start ? '0 : row_phase;
  assign blk = in_data.frame_start ? '0 : block_col;

  assign in_rect = (32'(c) >= 32'(x_lo)) && (32'(c) < 32'(x_hi)) &&
                   (32'(y) >= 32'(y_lo)) && (32'(y) < 32'(y_hi));
  // Block columns past the end of the store pass through untouched.
  assign hit       = in_rect && (32'(blk) < ANCHOR_DEPTH);
  assign is_anchor = hit && (cph == '0) && (rph == '0);
  assign blk_wide  = IXW'(blk);
  assign aidx      = blk_wide[AIW-1:0];

  // Raster advance. Phases restart where the position meets the region
  // origin and otherwise step through the block; away from the region
  // their value does not matter.
  always_comb begin
    col_last       = (32'(c) + 32'd1) >= 32'(cw);
    col_count_next = col_last ? '0 : c + CW'(1);
    row_count_next = y;
    row_phase_next = rph;
    if (col_last) begin
      row_count_next = ((32'(y) + 32'd1) >= 32'(ch)) ? '0 : y + RW'(1);
      if (32'(row_count_next) == 32'(y_lo)) begin
        row_phase_next = '0;
      end else if (rph == PW'(STEP - 1)) begin
        row_phase_next = '0;
      end else begin
        row_phase_next = rph + PW'(1);
      end
    end
    if (32'(col_count_next) == 32'(x_lo)) begin
      col_phase_next = '0;
      block_col_next = '0;
    end else if (cph == PW'(STEP - 1)) begin
      col_phase_next = '0;
      block_col_next = blk + CW'(1);
    end else begin
      col_phase_next = cph + PW'(1);
      block_col_next = blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      col_phase <= '0;
      row_phase <= '0;
      block_col <= '0;
    end else if (stat.load) begin
      col_phase <= col_phase_ld;
      row_phase <= row_phase_ld;
      block_col <= block_col_ld;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      col_phase <= col_phase_next;
      row_phase <= row_phase_next;
      block_col <= block_col_next;
    end
  end

  // The anchor pixel is written as its block is entered; later pixels of
  // the block read it back from the store. An anchor pixel reads the old
  // entry, but its own value is selected in the next stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_anchor) begin
        anchor_store[aidx] <= pix;
      end
      anchor_rd <= anchor_store[aidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_pix    <= pix;
      p_hit    <= hit;
      p_anchor <= is_anchor;
    end
  end

  assign res_pix       = (p_hit && !p_anchor) ? anchor_rd : p_pix;
  assign res.red_out   = res_pix[23:16];
  assign res.green_out = res_pix[15:8];
  assign res.blue_out  = res_pix[7:0];
  assign res.in_region = p_hit;

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  assign out_valid = fifo_count != 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_data  = fifo_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fifo_count <= 2'd0;
    end else begin
      if (p_move) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fifo_count <= fifo_count + {1'b0, p_move} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      fifo_q[wr_ptr] <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_queue_no_overflow : assert property (@(posedge clk) disable iff (rst)
    fifo_count == 2'd2 && !pop |=> fifo_count == 2'd2 && $stable(wr_ptr))
    else $error("output queue written while full");

  a_col_in_line : assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_write |=> 32'(col_count) < 32'($past(cw)))
    else $error("column counter left the line");

  a_row_in_frame : assert property (@(posedge clk) disable iff (rst)
    accept && col_last && !cfg_write |=> 32'(row_count) < 32'($past(ch)))
    else $error("row counter left the frame");

  a_no_item_while_busy : assert property (@(posedge clk) disable iff (rst)
    cfg_start |=> !accept)
    else $error("item accepted during a bounds recompute");

endmodule

FILE: verif/tb_region_block_mosaic.sv
// Self-checking testbench for the region block mosaic: a directed table then
// random frames, checked against typed-in results or a predictor in this file.
// Depends on rbm_pkg and region_block_mosaic; reads and writes no files.
module tb_region_block_mosaic;
  import rbm_pkg::*;

  localparam int STEP         = 10;
  localparam int MAX_COLS     = 2048;
  localparam int ANCHOR_DEPTH = 205;
  localparam int SCALE_DEN    = 10000;
  localparam int RANDOM_ITEMS = 650;
  localparam int DIR_ROWS     = 27;
  localparam int PRINT_CAP    = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACE_LEFT   = 0,
    REG_FACE_TOP    = 1,
    REG_FACE_WIDTH  = 2,
    REG_FACE_HEIGHT = 3,
    REG_FRAME_COLS  = 4,
    REG_FRAME_ROWS  = 5
  } cfg_reg_e;

  // How the receiver paces out_ready between long hold-offs.
  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

  // One row of the directed table: either a register write or a pixel item,
  // with the expected result typed in where it is obvious.
  typedef struct {
    bit        is_cfg;
    cfg_reg_e  idx;
    int        val;
    pix_in_t   px;
    bit        known;
    pix_out_t  want;
  } step_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pix_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pix_out_t              out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  region_block_mosaic #(
    .STEP(STEP), .MAX_COLS(MAX_COLS), .ANCHOR_DEPTH(ANCHOR_DEPTH)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the registers, the region bounds,
  // the raster position and the anchor line. anchor_seen records which
  // anchor entries have been written since reset, so that the stimulus can
  // steer clear of reading one that never was.
  // ---------------------------------------------------------------------
  logic [FACE_W-1:0]  face_left_r, face_top_r, face_width_r, face_height_r;
  logic [SIZE_W-1:0]  frame_cols_r, frame_rows_r;
  int                 x_lo, x_hi, y_lo, y_hi;
  int                 pos_col, pos_row;
  logic [PIX_W-1:0]   anchor_line [ANCHOR_DEPTH];
  bit                 anchor_seen [ANCHOR_DEPTH];

  pix_out_t due_pixels [$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       burst_left = 0;

  function automatic int sat_dim(input logic [SIZE_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Scales one axis of the face to pixels, widens it by a tenth on each side
  // and keeps a block's margin from the far edge. Empty when hi equals lo.
  function automatic void axis_span(input int org, input int len, input int span,
                                    output int lo, output int hi);
    longint p, w, s, ext, tmp;
    p = (longint'(org) * span) / SCALE_DEN;
    w = (longint'(len) * span) / SCALE_DEN;
    s = p - (w + 9) / 10;
    if (s < 0) s = 0;
    ext = (6 * w) / 5;
    if (s + ext + STEP > span) ext = span - s - STEP;
    lo = int'(s & 'hFFF);
    if (ext > 0) begin
      tmp = s + ((ext + STEP - 1) / STEP) * STEP;
      hi = int'(tmp & 'hFFF);
    end else begin
      hi = lo;
    end
  endfunction

  function automatic void refresh_bounds();
    axis_span(face_left_r, face_width_r, sat_dim(frame_cols_r, MAX_COLS), x_lo, x_hi);
    axis_span(face_top_r, face_height_r, sat_dim(frame_rows_r, MAX_ROWS), y_lo, y_hi);
  endfunction

  function automatic void apply_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FACE_LEFT:   face_left_r   = val;
      REG_FACE_TOP:    face_top_r    = val;
      REG_FACE_WIDTH:  face_width_r  = val;
      REG_FACE_HEIGHT: face_height_r = val;
      REG_FRAME_COLS:  frame_cols_r  = val[SIZE_W-1:0];
      REG_FRAME_ROWS:  frame_rows_r  = val[SIZE_W-1:0];
      default: ;
    endcase
    refresh_bounds();
  endfunction

  // True when a pixel at the next position would be replaced from an anchor
  // entry that has never been written.
  function automatic bit reads_blank_anchor(input bit fs);
    int c, y, dc, dr;
    c = fs ? 0 : pos_col;
    y = fs ? 0 : pos_row;
    if (c < x_lo || c >= x_hi || y < y_lo || y >= y_hi) return 0;
    dc = c - x_lo;
    dr = y - y_lo;
    if (dc / STEP >= ANCHOR_DEPTH) return 0;
    if (dc % STEP == 0 && dr % STEP == 0) return 0;
    return !anchor_seen[dc / STEP];
  endfunction

  // Works out the mosaic output for one pixel and advances the raster position.
  function automatic pix_out_t mosaic_step(input pix_in_t px);
    pix_out_t         res;
    int               c, y, dc, dr, blk;
    logic [PIX_W-1:0] rgb;
    rgb = {px.red_in, px.green_in, px.blue_in};
    res.in_region = 1'b0;
    if (px.frame_start) begin
      pos_col = 0;
      pos_row = 0;
    end
    c = pos_col;
    y = pos_row;
    if (c >= x_lo && c < x_hi && y >= y_lo && y < y_hi) begin
      dc  = c - x_lo;
      dr  = y - y_lo;
      blk = dc / STEP;
      if (blk < ANCHOR_DEPTH) begin
        res.in_region = 1'b1;
        if (dc % STEP == 0 && dr % STEP == 0) begin
          anchor_line[blk] = rgb;
          anchor_seen[blk] = 1'b1;
        end
        rgb = anchor_line[blk];
      end
    end
    {res.red_out, res.green_out, res.blue_out} = rgb;
    // A position left beyond a shrunken frame wraps at the next advance.
    if (c + 1 >= sat_dim(frame_cols_r, MAX_COLS)) begin
      pos_col = 0;
      pos_row = (y + 1 >= sat_dim(frame_rows_r, MAX_ROWS)) ? 0 : y + 1;
    end else begin
      pos_col = c + 1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side. Items go out in bursts of random length; between bursts
  // valid drops for a random gap, or not at all, so that some stretches run
  // back to back. Valid is never lowered at the edge where it is raised.
  // ---------------------------------------------------------------------
  task automatic send_pixel(input pix_in_t px, input bit known, input pix_out_t want);
    int       gap;
    pix_out_t guess;
    cfg_write <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    // Restarting the frame puts the item on an anchor or outside the region,
    // which keeps an unwritten anchor entry from ever being read.
    if (reads_blank_anchor(px.frame_start)) px.frame_start = 1'b1;
    in_data  <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    guess = mosaic_step(px);
    due_pixels.push_back(known ? want : guess);
  endtask

  // Register writes happen only once every expected result has come back,
  // so the block is idle apart from its own bounds recompute.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
    burst_left = 0;
  endtask

  function automatic int odd_size();
    case ($urandom_range(4, 0))
      0:       return 0;
      1:       return 1;
      2:       return MAX_COLS;
      3:       return 4095;
      default: return $urandom_range(4095, 0);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Receiver side and checker. Each accepted result is compared with the
  // oldest expectation. out_ready follows a mode that is redrawn at random,
  // with random hold-offs, and one long hold-off while the sender is still
  // offering items so that the block backs up and drops in_ready.
  // ---------------------------------------------------------------------
  rx_mode_e rx_mode = RX_FREE;
  int       rx_tick = 0;
  int       hold_left = 0;
  bit       long_hold_done = 1'b0;
  pix_out_t rx_want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_pixels.size() == 0) begin
          if (mismatches < PRINT_CAP)
            $display("%0t: unexpected result, got %h/%h/%h region %b", $time,
                     out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.in_region);
          mismatches++;
        end else begin
          rx_want = due_pixels.pop_front();
          if (out_data.red_out !== rx_want.red_out ||
              out_data.green_out !== rx_want.green_out ||
              out_data.blue_out !== rx_want.blue_out ||
              out_data.in_region !== rx_want.in_region) begin
            if (mismatches < PRINT_CAP)
              $display("%0t: expected %h/%h/%h region %b, got %h/%h/%h region %b",
                       $time, rx_want.red_out, rx_want.green_out, rx_want.blue_out,
                       rx_want.in_region, out_data.red_out, out_data.green_out,
                       out_data.blue_out, out_data.in_region);
            mismatches++;
          end
        end
        results_seen++;
      end

      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = rx_mode_e'($urandom_range(3, 0));
      if (hold_left == 0 && !long_hold_done && in_valid && results_seen >= 100) begin
        hold_left = 80;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && $urandom_range(599, 0) == 0) begin
        hold_left = $urandom_range(60, 20);
      end

      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:    out_ready <= 1'b1;
          RX_RANDOM:  out_ready <= ($urandom_range(3, 0) != 0);
          RX_PATTERN: out_ready <= (rx_tick % 3 != 0);
          default:    out_ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Directed table. After reset the region is empty, so items pass. A
  // 20 by 20 frame with a full face gives a region of one block at the
  // origin; the first pixel of the frame is its anchor and reports itself.
  // Zero frame sizes saturate to one pixel and leave no room for a block.
  // Oversized registers saturate the frame to 2048 and make the region span
  // nearly all of it; an origin far outside the frame empties it again.
  // ---------------------------------------------------------------------
  step_row_t dir_tab [DIR_ROWS] = '{
    '{1'b0, REG_FACE_LEFT,   0,     {8'hFF, 8'h00, 8'hAA, 1'b1}, 1'b1,
      {8'hFF, 8'h00, 8'hAA, 1'b0}},
    '{1'b0, REG_FACE_LEFT,   0,     {8'h00, 8'hFF, 8'h55, 1'b0}, 1'b1,
      {8'h00, 8'hFF, 8'h55, 1'b0}},
    '{1'b1, REG_FRAME_COLS,  20,    '0, 1'b0, '0},
    '{1'b1, REG_FRAME_ROWS,  20,    '0, 1'b0, '0},
    '{1'b1, REG_FACE_WIDTH,  10000, '0, 1'b0, '0},
    '{1'b1, REG_FACE_HEIGHT, 10000, '0, 1'b0, '0},
    '{1'b1, REG_FACE_LEFT,   0,     '0, 1'b0, '0},
    '{1'b1, REG_FACE_TOP,    0,     '0, 1'b0, '0},
    '{1'b0, REG_FACE_LEFT,   0,     {8'h12, 8'h34, 8'h56, 1'b1}, 1'b1,
      {8'h12, 8'h34, 8'h56, 1'b1}},
    '{1'b0, REG_FACE_LEFT,   0,     {8'hAB, 8'hCD, 8'hEF, 1'b0}, 1'b1,
      {8'h12, 8'h34, 8'h56, 1'b1}},
    '{1'b0, REG_FACE_LEFT,   0,     {8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, '0},
    '{1'b0, REG_FACE_LEFT,   0,     {8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
    '{1'b0, REG_FACE_LEFT,   0,     {8'h00, 8'hFF, 8'h00, 1'b1}, 1'b1,
      {8'h00, 8'hFF, 8'h00, 1'b1}},
    '{1'b1, REG_FRAME_COLS,  0,     '0, 1'b0, '0},
    '{1'b1, REG_FRAME_ROWS,  0,     '0, 1'b0, '0},
    '{1'b0, REG_FACE_LEFT,   0,     {8'h0F, 8'h0F, 8'h0F, 1'b1}, 1'b1,
      {8'h0F, 8'h0F, 8'h0F, 1'b0}},
    '{1'b0, REG_FACE_LEFT,   0,     {8'hF0, 8'hF0, 8'hF0, 1'b0}, 1'b1,
      {8'hF0, 8'hF0, 8'hF0, 1'b0}},
    '{1'b1, REG_FRAME_COLS,  4095,  '0, 1'b0, '0},
    '{1'b1, REG_FRAME_ROWS,  4095,  '0, 1'b0, '0},
    '{1'b1, REG_FACE_WIDTH,  16383, '0, 1'b0, '0},
    '{1'b1, REG_FACE_HEIGHT, 16383, '0, 1'b0, '0},
    '{1'b0, REG_FACE_LEFT,   0,     {8'h5A, 8'h5A, 8'h5A, 1'b1}, 1'b1,
      {8'h5A, 8'h5A, 8'h5A, 1'b1}},
    '{1'b0, REG_FACE_LEFT,   0,     {8'hA5, 8'hA5, 8'hA5, 1'b0}, 1'b1,
      {8'h5A, 8'h5A, 8'h5A, 1'b1}},
    '{1'b1, REG_FACE_LEFT,   16383, '0, 1'b0, '0},
    '{1'b0, REG_FACE_LEFT,   0,     {8'h3C, 8'h3C, 8'h3C, 1'b1}, 1'b1,
      {8'h3C, 8'h3C, 8'h3C, 1'b0}},
    '{1'b1, REG_FACE_TOP,    16383, '0, 1'b0, '0},
    '{1'b0, REG_FACE_LEFT,   0,     {8'hC3, 8'hC3, 8'hC3, 1'b0}, 1'b1,
      {8'hC3, 8'hC3, 8'hC3, 1'b0}}
  };

  initial begin
    int      i, k, n, area, kind, random_sent;
    bit      wide, fresh;
    int      new_val [6];
    pix_in_t px;

    face_left_r   = '0;
    face_top_r    = '0;
    face_width_r  = '0;
    face_height_r = '0;
    frame_cols_r  = 12'd640;
    frame_rows_r  = 12'd480;
    pos_col = 0;
    pos_row = 0;
    for (i = 0; i < ANCHOR_DEPTH; i++) begin
      anchor_line[i] = '0;
      anchor_seen[i] = 1'b0;
    end
    refresh_bounds();
    random_sent = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_pixel(dir_tab[i].px, dir_tab[i].known, dir_tab[i].want);
      end
    end

    // Random phases: each one rewrites a random subset of the registers and
    // then streams whole or partial frames. Most phases use small frames
    // with a face placed so that the region holds one or two block rows;
    // a few use saturating sizes or faces beyond the frame.
    while (random_sent < RANDOM_ITEMS) begin
      wide = ($urandom_range(9, 0) == 0);
      kind = $urandom_range(3, 0);
      if (kind < 2) begin
        new_val[REG_FACE_LEFT]   = $urandom_range(3000, 0);
        new_val[REG_FACE_TOP]    = $urandom_range(3000, 0);
        new_val[REG_FACE_WIDTH]  = $urandom_range(9000, 2500);
        new_val[REG_FACE_HEIGHT] = $urandom_range(9000, 2500);
      end else begin
        for (i = REG_FACE_LEFT; i <= REG_FACE_HEIGHT; i++)
          new_val[i] = (kind == 2) ? $urandom_range(SCALE_DEN, 0)
                                   : $urandom_range(16383, 0);
      end
      new_val[REG_FRAME_COLS] = wide ? odd_size() : $urandom_range(24, 12);
      new_val[REG_FRAME_ROWS] = wide ? odd_size() : $urandom_range(24, 11);
      for (i = 0; i < 6; i++)
        if ($urandom_range(3, 0) != 0) write_reg(cfg_reg_e'(i), new_val[i]);

      area = sat_dim(frame_cols_r, MAX_COLS) * sat_dim(frame_rows_r, MAX_ROWS);
      if (wide || area > 600) n = $urandom_range(60, 20);
      else if ($urandom_range(2, 0) == 0) n = $urandom_range(area, 1);
      else n = (area <= 300) ? area * $urandom_range(2, 1) : area;
      // Now and then a phase carries on from wherever the last one stopped,
      // which also leaves the position beyond a frame that has shrunk.
      fresh = ($urandom_range(9, 0) != 0);
      for (k = 0; k < n; k++) begin
        px.red_in      = $urandom_range(255, 0);
        px.green_in    = $urandom_range(255, 0);
        px.blue_in     = $urandom_range(255, 0);
        px.frame_start = (k == 0 && fresh) || (k != 0 && k % area == 0) ||
                         ($urandom_range(149, 0) == 0);
        send_pixel(px, 1'b0, '0);
        random_sent++;
      end
    end

    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rbm_pkg.sv
rtl/rbm_bounds.sv
rtl/region_block_mosaic.sv
verif/tb_region_block_mosaic.sv
